// ===== src/srgm_pkg.sv =====
// Shared types and constants for the stereo ring gain mixer.
package srgm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int FILL_BITS   = 10;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int CFG_IDX_BITS = 8;

    localparam logic signed [COEF_BITS-1:0] GAIN_UNITY = 16'sd4096;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE = 8'd1;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_MIX  = 1'b1
    } cmd_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;

    // per-beat side info carried down the pipe
    typedef struct packed
    {
        logic                 mixed;
        logic                 wakeup;
        logic                 dropped;
        logic [FILL_BITS-1:0] fill;
        sample_t              main_left;
        sample_t              main_right;
    } beat_info_t;

endpackage

// ===== src/stereo_ring_gain_mixer_core.sv =====
// Stereo frame ring with Q3.12 gain mixer onto a main bus, top level.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: frames + main samples, tuser: cmd, tlast
//  m_axis   | out | m_axis_tvalid/tready   | tdata: mixed samples + fill, tuser: flags
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data (gain, active)
//
// One beat per cycle sustained while m_axis_tready is high; each taken beat passes through
// ring read, multiply, then round/saturate into the output register.
// The ring is one memory with one write port (push) and one registered read port (pop).
// Reset clears pointers, fill count and halt flag, sets gain to unity and active to 0;
// ring contents are not cleared. m_axis_tready low while a beat is held at the output
// freezes the whole pipe, and s_axis_tready drops with it.
module stereo_ring_gain_mixer_core
    import srgm_pkg::*;
#(
    parameter int RING_FRAMES = 512
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [23:0] frame_left, [47:24] frame_right, [71:48] main_left, [95:72] main_right
    input  logic [95:0]             s_axis_tdata,
    // [0] cmd
    input  logic [0:0]              s_axis_tuser,
    input  logic                    s_axis_tlast,

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [23:0] out_left, [47:24] out_right, [57:48] fill_level, [63:58] zero
    output logic [63:0]             m_axis_tdata,
    // [0] mixed, [1] wakeup, [2] dropped
    output logic [2:0]              m_axis_tuser,
    output logic                    m_axis_tlast,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_data
);

    localparam int AW    = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
    localparam int CW    = $clog2(RING_FRAMES + 1);
    localparam int SCL_W = PROD_BITS - GAIN_FRAC;
    localparam int SUM_W = SCL_W + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(RING_FRAMES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_FRAMES);
    localparam prod_t         ROUND_HALF = PROD_BITS'(1 << (GAIN_FRAC - 1));
    localparam sample_t       SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t       SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // ring memory
    logic [2*SAMPLE_BITS-1:0] ring_mem [RING_FRAMES];
    logic [2*SAMPLE_BITS-1:0] rdata_reg;

    // control state
    logic [AW-1:0]              wp_reg, wp_next;
    logic [AW-1:0]              rp_reg, rp_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       halted_reg, halted_next;
    logic signed [COEF_BITS-1:0] gain_reg;
    logic                       active_reg;

    // pipeline
    logic       a_valid_reg, b_valid_reg, out_valid_reg;
    beat_info_t a_info_reg, b_info_reg, acc_info;
    prod_t      b_prod_l_reg, b_prod_r_reg;
    sample_t    out_left_reg, out_right_reg;
    beat_info_t out_info_reg;

    logic    adv, accept, cfg_we;
    logic    wr_en, rd_en;
    cmd_t    cmd;
    sample_t in_fl, in_fr, in_ml, in_mr;
    sample_t mix_left, mix_right;

    assign cmd   = cmd_t'(s_axis_tuser[0]);
    assign in_fl = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_fr = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_ml = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign in_mr = s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;
    assign cfg_we        = cfg_valid && cfg_ready;

    // ring control for the accepted beat
    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        acc_info    = '0;
        if (accept)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (cnt_reg == FULL_CNT)
                    begin
                        acc_info.dropped = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wp_next  = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    acc_info.main_left  = in_ml;
                    acc_info.main_right = in_mr;
                    if (active_reg && !halted_reg)
                    begin
                        if (cnt_reg == '0)
                        begin
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            rd_en           = 1'b1;
                            acc_info.mixed  = 1'b1;
                            acc_info.wakeup = (cnt_reg == FULL_CNT);
                            rp_next         = (rp_reg == LAST_IDX) ? '0 : rp_reg + AW'(1);
                            cnt_next        = cnt_reg - CW'(1);
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        halted_next = 1'b0;
                    end
                end
            endcase
            acc_info.fill = FILL_BITS'(cnt_next);
        end
        // deactivation discards everything queued
        if (cfg_we && (cfg_index == CFG_ACTIVE) && !cfg_data[0])
        begin
            rp_next  = wp_next;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
            gain_reg   <= GAIN_UNITY;
            active_reg <= 1'b0;
        end
        else
        begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GAIN:
                    begin
                        gain_reg <= cfg_data;
                    end
                    CFG_ACTIVE:
                    begin
                        active_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // push and pop never share a beat, so no same-entry collision in one cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wp_reg] <= {in_fr, in_fl};
        end
        if (rd_en)
        begin
            rdata_reg <= ring_mem[rp_reg];
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= accept;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // saturating round-and-add, one lane
    function automatic sample_t mix_lane(input sample_t main_s, input prod_t prod);
        prod_t                    rounded;
        logic signed [SCL_W-1:0]  scaled;
        logic signed [SUM_W-1:0]  total;
        logic [SUM_W-SAMPLE_BITS:0] top;
        sample_t                  res;
        rounded = prod + ROUND_HALF;
        scaled  = rounded[PROD_BITS-1:GAIN_FRAC];
        total   = {{(SUM_W-SAMPLE_BITS){main_s[SAMPLE_BITS-1]}}, main_s}
                + {scaled[SCL_W-1], scaled};
        top     = total[SUM_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
        begin
            res = total[SAMPLE_BITS-1:0];
        end
        else if (total[SUM_W-1])
        begin
            res = SAMPLE_MIN;
        end
        else
        begin
            res = SAMPLE_MAX;
        end
        return res;
    endfunction

    assign mix_left  = mix_lane(b_info_reg.main_left, b_prod_l_reg);
    assign mix_right = mix_lane(b_info_reg.main_right, b_prod_r_reg);

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_info_reg <= acc_info;
            b_info_reg <= a_info_reg;
            if (a_info_reg.mixed)
            begin
                b_prod_l_reg <= $signed(rdata_reg[SAMPLE_BITS-1:0]) * gain_reg;
                b_prod_r_reg <= $signed(rdata_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]) * gain_reg;
            end
            else
            begin
                b_prod_l_reg <= '0;
                b_prod_r_reg <= '0;
            end
            out_info_reg  <= b_info_reg;
            out_left_reg  <= mix_left;
            out_right_reg <= mix_right;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_info_reg.fill, out_right_reg, out_left_reg};
    assign m_axis_tuser  = {out_info_reg.dropped, out_info_reg.wakeup, out_info_reg.mixed};
    assign m_axis_tlast  = 1'b0;

endmodule
